// ===== hw/rtl/input_mixer_dc_peak_unit_defines.svh =====
// Assertion macros for the input mixer checker.
// Used by imdp_checker only; no other dependencies.
`ifndef INPUT_MIXER_DC_PEAK_UNIT_DEFINES_SVH
`define INPUT_MIXER_DC_PEAK_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IMDP_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("imdp: implication check failed");

// Next-cycle implication, disabled during reset.
`define IMDP_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("imdp: next-cycle check failed");

`endif

// ===== hw/rtl/imdp_pkg.sv =====
// Shared types, constants and helper functions of the input mixer.
// No dependencies.
package imdp_pkg;

    localparam int SMP_W  = 24;
    localparam int GAIN_W = 16;
    localparam int ACC_W  = 44;
    localparam int SUM_W  = 56;
    localparam int CNT_W  = 32;
    localparam int IDX_W  = 3;
    localparam int MASK_W = 8;
    localparam int CFG_W  = 24;
    localparam int PROD_W = 43;

    typedef enum logic [IDX_W-1:0] {
        CFG_STEREO   = 3'd0,
        CFG_STATS    = 3'd1,
        CFG_MASK     = 3'd2,
        CFG_HOLD     = 3'd3,
        CFG_DC_MIN   = 3'd4,
        CFG_DC_COEFF = 3'd5
    } t_cfg_idx;

    localparam logic [MASK_W-1:0] RST_MASK     = 8'hFF;
    localparam logic [23:0]       RST_HOLD     = 24'd48000;
    localparam logic [15:0]       RST_DC_MIN   = 16'd10000;
    localparam logic [15:0]       RST_DC_COEFF = 16'd64881;

    function automatic logic [SMP_W-1:0] f_abs(input logic signed [SMP_W-1:0] s);
        f_abs = s[SMP_W-1] ? SMP_W'(-s) : SMP_W'(s);
    endfunction

    function automatic logic signed [ACC_W-1:0] f_sat_acc(input logic signed [ACC_W:0] v);
        if (v[ACC_W] != v[ACC_W-1]) begin
            f_sat_acc = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            f_sat_acc = v[ACC_W-1:0];
        end
    endfunction

    function automatic logic signed [SMP_W-1:0] f_sat24(input logic signed [31:0] v);
        if (v > 32'sd8388607) begin
            f_sat24 = 24'sh7FFFFF;
        end else if (v < -32'sd8388608) begin
            f_sat24 = 24'sh800000;
        end else begin
            f_sat24 = v[SMP_W-1:0];
        end
    endfunction

endpackage

// ===== hw/rtl/imdp_div.sv =====
// Restoring divider, one quotient bit per cycle, for the DC average.
// Depends on imdp_pkg.
module imdp_div
    import imdp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SUM_W-1:0] i_dividend,
    input  logic [CNT_W-1:0] i_divisor,
    output logic             o_done,
    output logic [SUM_W-1:0] o_quot
);

    localparam int STEP_W = $clog2(SUM_W);

    logic [SUM_W-1:0]  r_q;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_dvs;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;
    logic [CNT_W:0]    w_rs;
    logic              w_ge;
    logic [CNT_W:0]    w_diff;

    assign w_rs   = {r_rem, r_q[SUM_W-1]};
    assign w_ge   = w_rs >= {1'b0, r_dvs};
    assign w_diff = w_rs - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(SUM_W - 1);
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_q   <= {r_q[SUM_W-2:0], w_ge};
                r_rem <= w_ge ? w_diff[CNT_W-1:0] : w_rs[CNT_W-1:0];
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== hw/rtl/input_mixer_dc_peak_unit.sv =====
// Top level of the input mixer with DC offset removal and peak metering.
// Depends on imdp_pkg and imdp_div.
//
// A sample request holds the input while the sequencer runs: STAT alone when its
// input is unselected, STAT, ML and AL in mono, and also MR and AR in stereo mode,
// around one shared 25x18 multiplier (stats, left mix, right mix). A request with
// frame_last also holds the input until its result is loaded into the output
// register. When a block ends with enough samples, each channel's DC update runs
// DVS, DIV and B1 to B3 around the 56-step restoring divider that forms sum/count;
// a stereo update does so for both channels. A frame result waits in an output
// register and holds the block only if a second result is ready before it is taken.
module input_mixer_dc_peak_unit
    import imdp_pkg::*;
#(
    parameter int NUM_INPUTS = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [IDX_W-1:0]        i_input_index,
    input  logic signed [SMP_W-1:0] i_sample_left,
    input  logic signed [SMP_W-1:0] i_sample_right,
    input  logic                    i_has_right,
    input  logic [GAIN_W-1:0]       i_gain,
    input  logic                    i_block_first,
    input  logic                    i_block_last,
    input  logic                    i_frame_last,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [SMP_W-1:0] o_mix_left,
    output logic signed [SMP_W-1:0] o_mix_right,
    output logic [SMP_W-1:0]        o_input_peak,
    output logic signed [SMP_W-1:0] o_dc_offset_left,
    output logic signed [SMP_W-1:0] o_dc_offset_right,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data
);

    localparam int NI = (NUM_INPUTS < (1 << IDX_W)) ? NUM_INPUTS : (1 << IDX_W);
    localparam int IW = (NI > 1) ? $clog2(NI) : 1;
    localparam int ND = 1 << IW;

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_STAT = 11'b00000000010,
        S_ML   = 11'b00000000100,
        S_AL   = 11'b00000001000,
        S_MR   = 11'b00000010000,
        S_AR   = 11'b00000100000,
        S_DVS  = 11'b00001000000,
        S_DIV  = 11'b00010000000,
        S_B1   = 11'b00100000000,
        S_B2   = 11'b01000000000,
        S_B3   = 11'b10000000000
    } t_state;

    t_state r_state;
    logic   r_done_pend;

    logic              r_stereo;
    logic              r_stats;
    logic [MASK_W-1:0] r_mask;
    logic [23:0]       r_hold;
    logic [15:0]       r_dcmin;
    logic [15:0]       r_coeff;

    logic [IDX_W-1:0]        r_idx;
    logic signed [SMP_W-1:0] r_sl;
    logic signed [SMP_W-1:0] r_sr;
    logic                    r_hr;
    logic [GAIN_W-1:0]       r_gain;
    logic                    r_bf;
    logic                    r_bl;
    logic                    r_fl;
    logic                    r_chan;
    logic                    r_neg;

    logic signed [ACC_W-1:0]  r_acc_l;
    logic signed [ACC_W-1:0]  r_acc_r;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] r_t;
    logic signed [SMP_W-1:0]  r_avg;

    logic [CNT_W-1:0]        r_cnt   [ND];
    logic [SMP_W-1:0]        r_peak  [ND];
    logic [CNT_W-1:0]        r_ptime [ND];
    logic [SUM_W-1:0]        r_suml  [ND];
    logic [SUM_W-1:0]        r_sumr  [ND];
    logic signed [SMP_W-1:0] r_dcl   [ND];
    logic signed [SMP_W-1:0] r_dcr   [ND];

    logic                    r_ov;
    logic signed [SMP_W-1:0] r_mix_l;
    logic signed [SMP_W-1:0] r_mix_r;
    logic [SMP_W-1:0]        r_opk;
    logic signed [SMP_W-1:0] r_odcl;
    logic signed [SMP_W-1:0] r_odcr;

    logic [IW-1:0]            w_ai;
    logic                     w_inrange;
    logic                     w_sel;
    logic signed [SMP_W-1:0]  w_sx;
    logic [CNT_W-1:0]         w_cnt1;
    logic [SMP_W-1:0]         w_pk0, w_pk1, w_pk2, w_al, w_ar;
    logic [CNT_W-1:0]         w_pt1, w_pt2;
    logic signed [24:0]       w_ma;
    logic [16:0]              w_mb;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [SMP_W-1:0]  w_dcsel;
    logic [SUM_W-1:0]         w_sumsel;
    logic [SUM_W-1:0]         w_mag;
    logic                     w_dc_upd;
    logic                     w_div_done;
    logic [SUM_W-1:0]         w_quot;
    logic signed [SMP_W-1:0]  w_avg;
    logic signed [ACC_W-1:0]  w_acc_nl, w_acc_nr;
    logic signed [ACC_W:0]    w_el, w_er;
    logic signed [ACC_W-1:0]  w_bt;
    logic signed [SMP_W-1:0]  w_blend;
    logic                     w_can_load;
    t_state                   n_state;

    assign w_ai      = r_idx[IW-1:0];
    assign w_inrange = 32'(r_idx) < NUM_INPUTS;
    assign w_sel     = w_inrange && r_mask[r_idx];
    assign w_sx      = r_hr ? r_sr : r_sl;
    assign w_cnt1    = r_cnt[w_ai] + 1'b1;

    always_comb begin
        w_pk0 = r_peak[w_ai];
        if (r_bf && ((r_cnt[w_ai] - r_ptime[w_ai]) > {8'b0, r_hold})) begin
            w_pk0 = '0;
        end
        w_al  = f_abs(r_sl);
        w_ar  = f_abs(w_sx);
        w_pk1 = w_pk0;
        w_pt1 = r_ptime[w_ai];
        if (w_al > w_pk0) begin
            w_pk1 = w_al;
            w_pt1 = r_cnt[w_ai];
        end
        w_pk2 = w_pk1;
        w_pt2 = w_pt1;
        if (r_stereo && (w_ar > w_pk1)) begin
            w_pk2 = w_ar;
            w_pt2 = w_cnt1;
        end
    end

    assign w_dcsel = r_chan ? r_dcr[w_ai] : r_dcl[w_ai];

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_ML: begin
                w_ma = 25'(r_sl) - 25'(r_dcl[w_ai]);
                w_mb = 17'(r_gain);
            end
            S_MR: begin
                w_ma = 25'(w_sx) - 25'(r_dcr[w_ai]);
                w_mb = 17'(r_gain);
            end
            S_B1: begin
                w_ma = 25'(w_dcsel);
                w_mb = 17'(r_coeff);
            end
            S_B2: begin
                w_ma = 25'(r_avg);
                w_mb = 17'h10000 - 17'(r_coeff);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = w_ma * $signed({1'b0, w_mb});

    assign w_acc_nl = f_sat_acc((ACC_W+1)'(r_acc_l) + (ACC_W+1)'(r_prod));
    assign w_acc_nr = f_sat_acc((ACC_W+1)'(r_acc_r) + (ACC_W+1)'(r_prod));

    assign w_sumsel = r_chan ? r_sumr[w_ai] : r_suml[w_ai];
    assign w_mag    = w_sumsel[SUM_W-1] ? (~w_sumsel + 1'b1) : w_sumsel;
    assign w_dc_upd = r_stats && r_bl && (r_cnt[w_ai] > {16'b0, r_dcmin});

    imdp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DVS),
        .i_dividend (w_mag),
        .i_divisor  (r_cnt[w_ai]),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_comb begin
        if (r_neg) begin
            w_avg = (w_quot > 56'h800000) ? 24'sh800000 : SMP_W'(~w_quot + 1'b1);
        end else begin
            w_avg = (w_quot > 56'h7FFFFF) ? 24'sh7FFFFF : SMP_W'(w_quot);
        end
    end

    assign w_bt    = ACC_W'(r_t) + ACC_W'(r_prod) + 44'sd32768;
    assign w_blend = f_sat24(32'(signed'(w_bt[ACC_W-1:16])));

    assign w_el = ((ACC_W+1)'(r_acc_l) + 45'sd8192) >>> 14;
    assign w_er = ((ACC_W+1)'(r_acc_r) + 45'sd8192) >>> 14;

    assign w_can_load = !r_ov || !i_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid && !r_done_pend) n_state = S_STAT;
            S_STAT: n_state = w_sel ? S_ML : S_IDLE;
            S_ML:   n_state = S_AL;
            S_AL: begin
                if (r_stereo) n_state = S_MR;
                else if (w_dc_upd) n_state = S_DVS;
                else n_state = S_IDLE;
            end
            S_MR:   n_state = S_AR;
            S_AR:   n_state = w_dc_upd ? S_DVS : S_IDLE;
            S_DVS:  n_state = S_DIV;
            S_DIV:  if (w_div_done) n_state = S_B1;
            S_B1:   n_state = S_B2;
            S_B2:   n_state = S_B3;
            S_B3:   n_state = (!r_chan && r_stereo) ? S_DVS : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_done_pend <= 1'b0;
            r_ov        <= 1'b0;
            r_stereo    <= 1'b0;
            r_stats     <= 1'b1;
            r_mask      <= RST_MASK;
            r_hold      <= RST_HOLD;
            r_dcmin     <= RST_DC_MIN;
            r_coeff     <= RST_DC_COEFF;
            r_acc_l     <= '0;
            r_acc_r     <= '0;
            r_chan      <= 1'b0;
            for (int k = 0; k < ND; k++) begin
                r_cnt[k]   <= '0;
                r_peak[k]  <= '0;
                r_ptime[k] <= '0;
                r_suml[k]  <= '0;
                r_sumr[k]  <= '0;
                r_dcl[k]   <= '0;
                r_dcr[k]   <= '0;
            end
        end else begin
            r_prod <= w_prod;

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_STEREO:   r_stereo <= i_cfg_data[0];
                    CFG_STATS:    r_stats  <= i_cfg_data[0];
                    CFG_MASK:     r_mask   <= i_cfg_data[MASK_W-1:0];
                    CFG_HOLD:     r_hold   <= i_cfg_data;
                    CFG_DC_MIN:   r_dcmin  <= i_cfg_data[15:0];
                    CFG_DC_COEFF: r_coeff  <= i_cfg_data[15:0];
                    default: ;
                endcase
            end

            if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end

            // finished request with frame_last: emit and clear the mix
            if (r_done_pend && w_can_load) begin
                r_done_pend <= 1'b0;
                r_ov        <= 1'b1;
                r_mix_l     <= f_sat24(32'(signed'(w_el[ACC_W-14:0])));
                r_mix_r     <= r_stereo ? f_sat24(32'(signed'(w_er[ACC_W-14:0]))) : '0;
                r_opk       <= w_inrange ? r_peak[w_ai] : '0;
                r_odcl      <= w_inrange ? r_dcl[w_ai] : '0;
                r_odcr      <= w_inrange ? r_dcr[w_ai] : '0;
                r_acc_l     <= '0;
                r_acc_r     <= '0;
            end

            if ((n_state == S_IDLE) && (r_state != S_IDLE) && r_fl) begin
                r_done_pend <= 1'b1;
            end

            r_state <= n_state;

            case (r_state)
                S_IDLE: begin
                    if (i_valid && !r_done_pend) begin
                        r_idx  <= i_input_index;
                        r_sl   <= i_sample_left;
                        r_sr   <= i_sample_right;
                        r_hr   <= i_has_right;
                        r_gain <= i_gain;
                        r_bf   <= i_block_first;
                        r_bl   <= i_block_last;
                        r_fl   <= i_frame_last;
                        r_chan <= 1'b0;
                    end
                end
                S_STAT: begin
                    if (w_sel && r_stats) begin
                        r_peak[w_ai]  <= w_pk2;
                        r_ptime[w_ai] <= w_pt2;
                        r_cnt[w_ai]   <= w_cnt1;
                        r_suml[w_ai]  <= r_suml[w_ai] + SUM_W'(r_sl);
                        if (r_stereo) begin
                            r_sumr[w_ai] <= r_sumr[w_ai] + SUM_W'(w_sx);
                        end
                    end
                end
                S_AL: r_acc_l <= w_acc_nl;
                S_AR: r_acc_r <= w_acc_nr;
                S_DVS: r_neg <= w_sumsel[SUM_W-1];
                S_DIV: if (w_div_done) r_avg <= w_avg;
                S_B2: r_t <= r_prod;
                S_B3: begin
                    if (r_chan) begin
                        r_dcr[w_ai] <= w_blend;
                    end else begin
                        r_dcl[w_ai] <= w_blend;
                    end
                    r_chan <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_stall           = (r_state != S_IDLE) || r_done_pend;
    assign o_valid           = r_ov;
    assign o_mix_left        = r_mix_l;
    assign o_mix_right       = r_mix_r;
    assign o_input_peak      = r_opk;
    assign o_dc_offset_left  = r_odcl;
    assign o_dc_offset_right = r_odcr;
    assign o_cfg_ready       = 1'b1;

endmodule

// ===== hw/rtl/imdp_checker.sv =====
// Port-level checks of the input mixer, bound to the top level.
// Depends on input_mixer_dc_peak_unit_defines.svh.
`include "input_mixer_dc_peak_unit_defines.svh"

module imdp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [23:0] o_mix_left,
    input logic [23:0] o_input_peak
);

    `IMDP_ASSERT_NXT(a_busy_after_req, i_valid && !o_stall, o_stall)
    `IMDP_ASSERT_NXT(a_no_early_result, i_valid && !o_stall && !o_valid, !o_valid)
    `IMDP_ASSERT_IMP(a_peak_range, o_valid, o_input_peak <= 24'h800000)
    `IMDP_ASSERT_NXT(a_result_held, o_valid && i_stall, o_valid && $stable(o_mix_left))

endmodule

bind input_mixer_dc_peak_unit imdp_checker u_imdp_checker (.*);

// ===== sim/input_mixer_dc_peak_unit_tb.sv =====
// Testbench for input_mixer_dc_peak_unit: directed and random sample requests,
// checked against an in-bench predictor of mix, peak and DC offset tracking.
// Depends on imdp_pkg and the input_mixer_dc_peak_unit RTL.
`timescale 1ns / 100ps

module input_mixer_dc_peak_unit_tb;
    import imdp_pkg::*;

    typedef struct {
        logic [IDX_W-1:0]        idx;
        logic signed [SMP_W-1:0] sl;
        logic signed [SMP_W-1:0] sr;
        logic                    has_r;
        logic [GAIN_W-1:0]       gain;
        logic                    bfirst;
        logic                    blast;
        logic                    flast;
    } t_mix_req;

    typedef struct {
        logic signed [SMP_W-1:0] mix_l;
        logic signed [SMP_W-1:0] mix_r;
        logic [SMP_W-1:0]        peak;
        logic signed [SMP_W-1:0] dc_l;
        logic signed [SMP_W-1:0] dc_r;
    } t_frame_res;

    localparam longint ACC_MAX = (64'sd1 <<< 43) - 1;
    localparam longint SMP_MAX = 64'sd8388607;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic [IDX_W-1:0]        i_input_index = '0;
    logic signed [SMP_W-1:0] i_sample_left = '0;
    logic signed [SMP_W-1:0] i_sample_right = '0;
    logic                    i_has_right = 1'b0;
    logic [GAIN_W-1:0]       i_gain = '0;
    logic                    i_block_first = 1'b0;
    logic                    i_block_last = 1'b0;
    logic                    i_frame_last = 1'b0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic signed [SMP_W-1:0] o_mix_left;
    logic signed [SMP_W-1:0] o_mix_right;
    logic [SMP_W-1:0]        o_input_peak;
    logic signed [SMP_W-1:0] o_dc_offset_left;
    logic signed [SMP_W-1:0] o_dc_offset_right;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [IDX_W-1:0]        i_cfg_index = '0;
    logic [CFG_W-1:0]        i_cfg_data = '0;

    int fail_count = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;

    input_mixer_dc_peak_unit i_dut (.*);

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input longint got, input longint exp);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
        fail_count++;
    endtask

    class mixer_scoreboard;
        logic        stereo;
        logic        stats;
        logic [7:0]  mask;
        logic [23:0] hold;
        logic [15:0] dc_min;
        logic [15:0] coeff;
        longint      acc_l;
        longint      acc_r;
        logic [31:0] cnt [8];
        logic [23:0] peak [8];
        logic [31:0] ptime [8];
        logic [55:0] sum_l [8];
        logic [55:0] sum_r [8];
        longint      dc_l [8];
        longint      dc_r [8];
        t_frame_res  frames_due [$];

        function new();
            stereo = 1'b0;
            stats = 1'b1;
            mask = RST_MASK;
            hold = RST_HOLD;
            dc_min = RST_DC_MIN;
            coeff = RST_DC_COEFF;
            acc_l = 0;
            acc_r = 0;
            for (int i = 0; i < 8; i++) begin
                cnt[i] = '0;
                peak[i] = '0;
                ptime[i] = '0;
                sum_l[i] = '0;
                sum_r[i] = '0;
                dc_l[i] = 0;
                dc_r[i] = 0;
            end
        endfunction

        function void set_reg(t_cfg_idx r, logic [CFG_W-1:0] d);
            case (r)
                CFG_STEREO:   stereo = d[0];
                CFG_STATS:    stats = d[0];
                CFG_MASK:     mask = d[7:0];
                CFG_HOLD:     hold = d;
                CFG_DC_MIN:   dc_min = d[15:0];
                CFG_DC_COEFF: coeff = d[15:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return frames_due.size();
        endfunction

        function longint clamp(longint x, longint lo, longint hi);
            return x < lo ? lo : (x > hi ? hi : x);
        endfunction

        function void peak_update(int i, longint s, logic [31:0] when);
            longint a;
            a = s < 0 ? -s : s;
            if (a > longint'(peak[i])) begin
                peak[i] = a[23:0];
                ptime[i] = when;
            end
        endfunction

        function longint blend(longint dc, logic [55:0] sbits, logic [31:0] n);
            longint sum;
            longint mag;
            longint q;
            longint avg;
            longint t;
            sum = longint'(signed'(sbits));
            mag = sum < 0 ? -sum : sum;
            q = mag / longint'(n);
            if (sum < 0) avg = q > SMP_MAX + 1 ? -SMP_MAX - 1 : -q;
            else avg = q > SMP_MAX ? SMP_MAX : q;
            t = longint'(coeff) * dc + (65536 - longint'(coeff)) * avg + 32768;
            return clamp(t >>> 16, -SMP_MAX - 1, SMP_MAX);
        endfunction

        function longint round_out(longint acc);
            return clamp((acc + 8192) >>> 14, -SMP_MAX - 1, SMP_MAX);
        endfunction

        function void note_request(t_mix_req r);
            int i;
            longint sl;
            longint sx;
            longint dl;
            longint dr;
            t_frame_res f;
            i = r.idx;
            sl = r.sl;
            sx = r.has_r ? longint'(r.sr) : sl;
            if (mask[i]) begin
                dl = dc_l[i];
                dr = dc_r[i];
                if (stats) begin
                    if (r.bfirst && (cnt[i] - ptime[i]) > {8'd0, hold}) peak[i] = '0;
                    sum_l[i] = sum_l[i] + 56'(sl);
                    peak_update(i, sl, cnt[i]);
                    cnt[i] = cnt[i] + 1;
                    if (stereo) begin
                        sum_r[i] = sum_r[i] + 56'(sx);
                        peak_update(i, sx, cnt[i]);
                    end
                end
                acc_l = clamp(acc_l + (sl - dl) * longint'(r.gain), -ACC_MAX - 1, ACC_MAX);
                if (stereo)
                    acc_r = clamp(acc_r + (sx - dr) * longint'(r.gain), -ACC_MAX - 1, ACC_MAX);
                if (stats && r.blast && cnt[i] > {16'd0, dc_min}) begin
                    dc_l[i] = blend(dl, sum_l[i], cnt[i]);
                    if (stereo) dc_r[i] = blend(dr, sum_r[i], cnt[i]);
                end
            end
            if (r.flast) begin
                f.mix_l = round_out(acc_l);
                f.mix_r = stereo ? round_out(acc_r) : '0;
                f.peak = peak[i];
                f.dc_l = dc_l[i];
                f.dc_r = dc_r[i];
                frames_due.push_back(f);
                acc_l = 0;
                acc_r = 0;
            end
        endfunction

        task check_result(t_frame_res got);
            t_frame_res e;
            if (frames_due.size() == 0) begin
                report_mismatch("unexpected frame, mix_left", got.mix_l, 0);
                return;
            end
            e = frames_due.pop_front();
            if (got.mix_l !== e.mix_l) report_mismatch("mix_left", got.mix_l, e.mix_l);
            if (got.mix_r !== e.mix_r) report_mismatch("mix_right", got.mix_r, e.mix_r);
            if (got.peak !== e.peak) report_mismatch("input_peak", got.peak, e.peak);
            if (got.dc_l !== e.dc_l) report_mismatch("dc_offset_left", got.dc_l, e.dc_l);
            if (got.dc_r !== e.dc_r) report_mismatch("dc_offset_right", got.dc_r, e.dc_r);
        endtask
    endclass

    mixer_scoreboard sb = new();

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_frame_res got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.mix_l = o_mix_left;
            got.mix_r = o_mix_right;
            got.peak = o_input_peak;
            got.dc_l = o_dc_offset_left;
            got.dc_r = o_dc_offset_right;
            sb.check_result(got);
        end
    end

    initial begin
        #10ms;
        $display("input_mixer_dc_peak_unit_tb failed");
        $finish;
    end

    task automatic send(input t_mix_req r);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_input_index <= r.idx;
        i_sample_left <= r.sl;
        i_sample_right <= r.sr;
        i_has_right <= r.has_r;
        i_gain <= r.gain;
        i_block_first <= r.bfirst;
        i_block_last <= r.blast;
        i_frame_last <= r.flast;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(r);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic st, input logic cs, input logic [7:0] m,
                              input logic [23:0] h, input logic [15:0] dm,
                              input logic [15:0] dcc);
        logic [CFG_W-1:0] vals [6];
        vals[0] = {23'd0, st};
        vals[1] = {23'd0, cs};
        vals[2] = {16'd0, m};
        vals[3] = h;
        vals[4] = {8'd0, dm};
        vals[5] = {8'd0, dcc};
        for (int k = 0; k < 6; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= t_cfg_idx'(k);
            i_cfg_data <= vals[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            sb.set_reg(t_cfg_idx'(k), vals[k]);
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [SMP_W-1:0] rnd_sample();
        case ($urandom_range(9))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2, 3: return 24'($urandom_range(4000)) - 24'd2000 + 24'd300000;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic t_mix_req rnd_req(int idx);
        t_mix_req r;
        r.idx = idx[IDX_W-1:0];
        r.sl = rnd_sample();
        r.sr = rnd_sample();
        r.has_r = 1'($urandom_range(1));
        r.gain = ($urandom_range(3) == 0) ? 16'h4000 : 16'($urandom);
        r.bfirst = 1'($urandom_range(1));
        r.blast = 1'($urandom_range(1));
        r.flast = 1'($urandom_range(1));
        return r;
    endfunction

    task automatic run_random(input int n, input bit pressure, input bit pause);
        int sent;
        int nfr;
        int sel [$];
        t_mix_req r;
        sent = 0;
        while (sent < n) begin
            if (pressure && sent >= n / 2) begin
                hold_left = 400;
                pressure = 0;
            end
            if (pause && sent >= n / 2) begin
                drain();
                pause = 0;
            end
            if ($urandom_range(99) < 15) begin
                send(rnd_req($urandom_range(7)));
                sent++;
                continue;
            end
            sel.delete();
            for (int i = 0; i < 8; i++) if (sb.mask[i]) sel.push_back(i);
            if (sel.size() == 0) begin
                r = rnd_req($urandom_range(7));
                r.flast = 1'b1;
                send(r);
                sent++;
                continue;
            end
            nfr = $urandom_range(4, 1);
            for (int f = 0; f < nfr; f++) begin
                foreach (sel[k]) begin
                    r = rnd_req(sel[k]);
                    r.bfirst = (f == 0);
                    r.blast = (f == nfr - 1);
                    r.flast = (k == sel.size() - 1);
                    send(r);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        t_mix_req r;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_regs(1'b1, 1'b1, 8'hFF, 24'd0, 16'd0, 16'hFFFF);

        // accumulate past full scale with no frame end, then emit
        for (int k = 0; k < 12; k++) begin
            r.idx = k[2:0];
            r.sl = (k < 6) ? 24'sh7FFFFF : 24'sh800000;
            r.sr = 24'sh800000;
            r.has_r = k[0];
            r.gain = 16'hFFFF;
            r.bfirst = (k < 8);
            r.blast = (k >= 4);
            r.flast = (k == 11);
            send(r);
        end
        for (int k = 0; k < 8; k++) begin
            r.idx = 3'd7 - k[2:0];
            r.sl = k[0] ? 24'sh000001 : -24'sd1;
            r.sr = 24'sh7FFFFF;
            r.has_r = ~k[0];
            r.gain = k[1] ? 16'h0000 : 16'h4000;
            r.bfirst = 1'b1;
            r.blast = 1'b1;
            r.flast = 1'b1;
            send(r);
        end

        drain();
        write_regs(1'b0, 1'b1, 8'hA5, 24'd2, 16'd1, 16'd0);
        run_random(180, 1, 0);

        drain();
        write_regs(1'b1, 1'b0, 8'hFF, 24'hFFFFFF, 16'hFFFF, RST_DC_COEFF);
        idle_pct = 83;
        run_random(150, 0, 0);

        drain();
        write_regs(1'b1, 1'b1, 8'($urandom), 24'd5, 16'd3, 16'($urandom));
        idle_pct = 0;
        stall_pct = 83;
        run_random(150, 0, 1);

        drain();
        write_regs(1'b1, 1'b1, 8'h00, 24'd1, 16'd0, 16'd32768);
        stall_pct = 0;
        run_random(20, 0, 0);

        drain();
        write_regs(1'($urandom), 1'b1, 8'hFF, 24'd1, 16'd0, 16'd32768);
        idle_pct = 16;
        stall_pct = 16;
        run_random(200, 0, 0);

        drain();
        idle_pct = 0;
        stall_pct = 0;
        run_random(100, 1, 0);
        drain();

        if (fail_count == 0) begin
            $display("input_mixer_dc_peak_unit_tb passed");
        end else begin
            $display("input_mixer_dc_peak_unit_tb failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/imdp_pkg.sv
hw/rtl/imdp_div.sv
hw/rtl/input_mixer_dc_peak_unit.sv
hw/rtl/imdp_checker.sv
sim/input_mixer_dc_peak_unit_tb.sv
